[rtl/core/erc_pkg.sv]
// Shared constants and types for the exact rational comparator.
package erc_pkg;

    localparam int MAG_WIDTH_DEF = 128;
    localparam int HALF_WIDTH    = 64;

    localparam logic signed [1:0] ORDER_LT = 2'sb11;
    localparam logic signed [1:0] ORDER_EQ = 2'sb00;
    localparam logic signed [1:0] ORDER_GT = 2'sb01;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/core/exact_rational_compare.sv]
// Top level: exact sign-magnitude rational comparison by continued fractions.
// Compares a = an/ad with b = bn/bd exactly and returns order -1, 0 or 1 (first smaller,
// equal, first larger). A zero denominator on either side gives zero_denominator = 1 and
// order 0; differing signs decide at once (a zero given with sign 1 counts as below zero).
// Those cases go straight from S_IDLE to S_HOLD. Otherwise each continued-fraction
// round runs two divisions, one per side, on one shared bit-serial divider, and
// the number of rounds depends on the data and is small for values of ordinary size.
// Magnitude bits above MAG_WIDTH are ignored.
// One item is in flight at a time; the result sits in an output register and the next
// item may be accepted while it waits.
module exact_rational_compare #(
    parameter int MAG_WIDTH = erc_pkg::MAG_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_a_negative,
    input  logic [63:0]             i_a_num_lo,
    input  logic [63:0]             i_a_num_hi,
    input  logic [63:0]             i_a_den_lo,
    input  logic [63:0]             i_a_den_hi,
    input  logic                    i_b_negative,
    input  logic [63:0]             i_b_num_lo,
    input  logic [63:0]             i_b_num_hi,
    input  logic [63:0]             i_b_den_lo,
    input  logic [63:0]             i_b_den_hi,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [1:0]       o_order,
    output logic                    o_zero_denominator
);

    localparam int FullW = 2 * erc_pkg::HALF_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_START_A = 7'b0000010,
        S_DIV_A   = 7'b0000100,
        S_START_B = 7'b0001000,
        S_DIV_B   = 7'b0010000,
        S_EVAL    = 7'b0100000,
        S_HOLD    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [MAG_WIDTH-1:0] r_a_num, n_a_num, r_a_den, n_a_den;
    logic [MAG_WIDTH-1:0] r_b_num, n_b_num, r_b_den, n_b_den;
    logic [MAG_WIDTH-1:0] r_qa, n_qa, r_ra, n_ra;
    logic                 r_dir, n_dir;
    logic signed [1:0]    r_res_order, n_res_order;
    logic                 r_res_zd, n_res_zd;
    logic                 r_out_valid, n_out_valid;
    logic signed [1:0]    r_order, n_order;
    logic                 r_zd, n_zd;

    logic [FullW-1:0]     a_num_full, a_den_full, b_num_full, b_den_full;
    logic [MAG_WIDTH-1:0] in_a_num, in_a_den, in_b_num, in_b_den;

    erc_pkg::t_div_ctl    div_ctl;
    erc_pkg::t_div_stat   div_stat;
    logic [MAG_WIDTH-1:0] div_num, div_den, div_quo, div_rem;

    logic                 ra_zero, rb_zero, q_lt;

    assign a_num_full = {i_a_num_hi, i_a_num_lo};
    assign a_den_full = {i_a_den_hi, i_a_den_lo};
    assign b_num_full = {i_b_num_hi, i_b_num_lo};
    assign b_den_full = {i_b_den_hi, i_b_den_lo};
    assign in_a_num   = a_num_full[MAG_WIDTH-1:0];
    assign in_a_den   = a_den_full[MAG_WIDTH-1:0];
    assign in_b_num   = b_num_full[MAG_WIDTH-1:0];
    assign in_b_den   = b_den_full[MAG_WIDTH-1:0];

    assign div_ctl.start = (r_state == S_START_A) || (r_state == S_START_B);
    assign div_num       = (r_state == S_START_A) ? r_a_num : r_b_num;
    assign div_den       = (r_state == S_START_A) ? r_a_den : r_b_den;

    erc_div #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign ra_zero = (r_ra == '0);
    assign rb_zero = (div_rem == '0);
    assign q_lt    = (r_qa < div_quo);

    always_comb begin
        n_state     = r_state;
        n_a_num     = r_a_num;
        n_a_den     = r_a_den;
        n_b_num     = r_b_num;
        n_b_den     = r_b_den;
        n_qa        = r_qa;
        n_ra        = r_ra;
        n_dir       = r_dir;
        n_res_order = r_res_order;
        n_res_zd    = r_res_zd;
        n_out_valid = r_out_valid;
        n_order     = r_order;
        n_zd        = r_zd;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a_num  = in_a_num;
                    n_a_den  = in_a_den;
                    n_b_num  = in_b_num;
                    n_b_den  = in_b_den;
                    n_dir    = i_a_negative;
                    n_res_zd = 1'b0;
                    if (in_a_den == '0 || in_b_den == '0) begin
                        n_res_order = erc_pkg::ORDER_EQ;
                        n_res_zd    = 1'b1;
                        n_state     = S_HOLD;
                    end else if (i_a_negative != i_b_negative) begin
                        n_res_order = i_a_negative ? erc_pkg::ORDER_LT : erc_pkg::ORDER_GT;
                        n_state     = S_HOLD;
                    end else begin
                        n_state = S_START_A;
                    end
                end
            end
            S_START_A: n_state = S_DIV_A;
            S_DIV_A: begin
                if (div_stat.done) begin
                    n_qa    = div_quo;
                    n_ra    = div_rem;
                    n_state = S_START_B;
                end
            end
            S_START_B: n_state = S_DIV_B;
            S_DIV_B: begin
                if (div_stat.done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // direction flips the sense of every other partial quotient
                if (r_qa != div_quo) begin
                    n_res_order = (q_lt ^ r_dir) ? erc_pkg::ORDER_LT : erc_pkg::ORDER_GT;
                    n_state     = S_HOLD;
                end else if (ra_zero || rb_zero) begin
                    if (ra_zero && rb_zero) begin
                        n_res_order = erc_pkg::ORDER_EQ;
                    end else begin
                        n_res_order = (ra_zero ^ r_dir) ? erc_pkg::ORDER_LT
                                                        : erc_pkg::ORDER_GT;
                    end
                    n_state = S_HOLD;
                end else begin
                    n_a_num = r_a_den;
                    n_a_den = r_ra;
                    n_b_num = r_b_den;
                    n_b_den = div_rem;
                    n_dir   = ~r_dir;
                    n_state = S_START_A;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_order     = r_res_order;
                    n_zd        = r_res_zd;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a_num     <= n_a_num;
        r_a_den     <= n_a_den;
        r_b_num     <= n_b_num;
        r_b_den     <= n_b_den;
        r_qa        <= n_qa;
        r_ra        <= n_ra;
        r_dir       <= n_dir;
        r_res_order <= n_res_order;
        r_res_zd    <= n_res_zd;
        r_order     <= n_order;
        r_zd        <= n_zd;
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_order            = r_order;
    assign o_zero_denominator = r_zd;

`ifndef SYNTH
    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV_A || r_state == S_DIV_B))
        else $error("divider finished outside a wait state");

    a_zd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_res_zd) |-> (r_res_order == erc_pkg::ORDER_EQ))
        else $error("zero denominator with nonzero order");

    a_no_bad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_order != 2'sb10) && $past(r_state == S_HOLD))
        else $error("result not loaded from hold state");
`endif

endmodule

[rtl/core/erc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module erc_div #(
    parameter int MAG_WIDTH = erc_pkg::MAG_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  erc_pkg::t_div_ctl     i_ctl,
    input  logic [MAG_WIDTH-1:0]  i_num,
    input  logic [MAG_WIDTH-1:0]  i_den,
    output erc_pkg::t_div_stat    o_stat,
    output logic [MAG_WIDTH-1:0]  o_quo,
    output logic [MAG_WIDTH-1:0]  o_rem
);

    localparam int CntW = $clog2(MAG_WIDTH + 1);

    logic [CntW-1:0]      r_cnt,  n_cnt;
    logic                 r_done, n_done;
    logic [MAG_WIDTH-1:0] r_rem,  n_rem;
    logic [MAG_WIDTH-1:0] r_quo,  n_quo;   // numerator bits out, quotient bits in
    logic [MAG_WIDTH-1:0] r_den,  n_den;

    logic [MAG_WIDTH:0]   rem_sh;
    logic [MAG_WIDTH+1:0] diff;
    logic                 fits;

    // shifted remainder keeps the carry bit so divisors near full range work
    assign rem_sh = {r_rem, r_quo[MAG_WIDTH-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign fits   = ~diff[MAG_WIDTH+1];

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_ctl.start) begin
            n_cnt = CntW'(MAG_WIDTH);
            n_rem = '0;
            n_quo = i_num;
            n_den = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CntW'(1);
            n_rem = fits ? diff[MAG_WIDTH-1:0] : rem_sh[MAG_WIDTH-1:0];
            n_quo = {r_quo[MAG_WIDTH-2:0], fits};
            if (r_cnt == CntW'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule
